### sv/xenc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// xenc_pkg: shared types and constants of the x86-64 instruction encoder
// Holds the request layout, the encoded-instruction buffer type and the
// instruction form codes.
// ---------------------------------------------------------------------------
package xenc_pkg;

    localparam int POSITION_BITS  = 32;
    localparam int MAX_INSN_BYTES = 12;
    localparam int CNT_W          = $clog2(MAX_INSN_BYTES + 1);
    localparam int IDX_W          = $clog2(MAX_INSN_BYTES);
    localparam int IN_DATA_W      = 96;
    localparam int REQ_W          = 90;

    localparam logic [4:0] KIND_CQO       = 5'd0;
    localparam logic [4:0] KIND_PUSH_R    = 5'd1;
    localparam logic [4:0] KIND_POP_R     = 5'd2;
    localparam logic [4:0] KIND_PUSH_M    = 5'd3;
    localparam logic [4:0] KIND_POP_M     = 5'd4;
    localparam logic [4:0] KIND_CMP_RR    = 5'd5;
    localparam logic [4:0] KIND_CMP_RI    = 5'd6;
    localparam logic [4:0] KIND_EXIT      = 5'd7;
    localparam logic [4:0] KIND_IN        = 5'd8;
    localparam logic [4:0] KIND_OUT       = 5'd9;
    localparam logic [4:0] KIND_LEA       = 5'd10;
    localparam logic [4:0] KIND_RET       = 5'd11;
    localparam logic [4:0] KIND_SETCC     = 5'd12;
    localparam logic [4:0] KIND_CALL      = 5'd13;
    localparam logic [4:0] KIND_JMP       = 5'd14;
    localparam logic [4:0] KIND_TEST      = 5'd15;
    localparam logic [4:0] KIND_INC       = 5'd16;
    localparam logic [4:0] KIND_DEC       = 5'd17;
    localparam logic [4:0] KIND_MOV_RR    = 5'd18;
    localparam logic [4:0] KIND_MOV_RM    = 5'd19;
    localparam logic [4:0] KIND_MOV_MR    = 5'd20;
    localparam logic [4:0] KIND_MOV_RMD   = 5'd21;
    localparam logic [4:0] KIND_MOV_MDR   = 5'd22;
    localparam logic [4:0] KIND_MOV_RI    = 5'd23;
    localparam logic [4:0] KIND_ALU       = 5'd24;
    localparam logic [4:0] KIND_IMUL      = 5'd25;
    localparam logic [4:0] KIND_IDIV      = 5'd26;
    localparam logic [4:0] KIND_SHL       = 5'd27;
    localparam logic [4:0] KIND_SHR       = 5'd28;

    typedef struct packed {
        logic [7:0]  alu_opcode;
        logic [31:0] target_offset;
        logic [31:0] immediate;
        logic [4:0]  condition;
        logic [3:0]  second_reg;
        logic [3:0]  first_reg;
        logic [4:0]  kind;
    } req_t;

    typedef struct packed {
        logic [MAX_INSN_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]               count;
    } enc_t;

endpackage : xenc_pkg
`default_nettype wire

### sv/xenc_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// xenc_encoder: combinational instruction encoder
// Turns one registered request and the current byte position into the byte
// image of the instruction and its length.
// ---------------------------------------------------------------------------
module xenc_encoder
    import xenc_pkg::*;
(
    input  var req_t                     req,
    input  wire logic [POSITION_BITS-1:0] position,
    output enc_t                         enc
);

    function automatic enc_t put(enc_t e, logic [7:0] v);
        enc_t r;
        r = e;
        if (int'(e.count) < MAX_INSN_BYTES)
        begin
            r.bytes[e.count[IDX_W-1:0]] = v;
            r.count = CNT_W'(e.count + 1'b1);
        end
        return r;
    endfunction

    function automatic enc_t put32(enc_t e, logic [31:0] v);
        enc_t r;
        r = put(e, v[7:0]);
        r = put(r, v[15:8]);
        r = put(r, v[23:16]);
        r = put(r, v[31:24]);
        return r;
    endfunction

    function automatic logic [7:0] rexw(logic [3:0] rg, logic [3:0] rm);
        return {5'b01001, rg[3], 1'b0, rm[3]};
    endfunction

    function automatic logic [7:0] modrm(logic [1:0] md, logic [3:0] rg, logic [3:0] rm);
        return {md, rg[2:0], rm[2:0]};
    endfunction

    function automatic enc_t mem_disp32(enc_t e, logic [3:0] rg, logic [3:0] base,
                                        logic [31:0] disp);
        enc_t r;
        r = put(e, modrm(2'd2, rg, base));
        if (base[2:0] == 3'd4)
        begin
            r = put(r, 8'h24);
        end
        r = put32(r, disp);
        return r;
    endfunction

    function automatic enc_t mem_plain(enc_t e, logic [3:0] rg, logic [3:0] base);
        enc_t r;
        if (base[2:0] == 3'd5)
        begin
            r = put(e, modrm(2'd1, rg, base));
            r = put(r, 8'h00);
        end
        else
        begin
            r = put(e, modrm(2'd0, rg, base));
            if (base[2:0] == 3'd4)
            begin
                r = put(r, 8'h24);
            end
        end
        return r;
    endfunction

    function automatic enc_t opt_rex_b(enc_t e, logic [3:0] rg);
        enc_t r;
        r = e;
        if (rg[3])
        begin
            r = put(e, 8'h41);
        end
        return r;
    endfunction

    logic [POSITION_BITS+31:0] pos_wide;
    logic [31:0]               pos_low;
    logic [31:0]               rel_near;
    logic [31:0]               rel_cond;
    logic [3:0]                r1;
    logic [3:0]                r2;

    assign r1       = req.first_reg;
    assign r2       = req.second_reg;
    assign pos_wide = {32'd0, position};
    assign pos_low  = pos_wide[31:0];
    // Targets are relative to the end of the instruction: five bytes for call
    // and jmp, six for a conditional jump.
    assign rel_near = req.target_offset - (pos_low + 32'd5);
    assign rel_cond = req.target_offset - (pos_low + 32'd6);

    always_comb
    begin
        enc_t e;
        e = '0;
        unique case (req.kind)
            KIND_CQO:     begin e = put(e, 8'h48); e = put(e, 8'h99); end
            KIND_PUSH_R:  begin e = opt_rex_b(e, r1); e = put(e, {5'b01010, r1[2:0]}); end
            KIND_POP_R:   begin e = opt_rex_b(e, r1); e = put(e, {5'b01011, r1[2:0]}); end
            KIND_PUSH_M:
            begin
                e = opt_rex_b(e, r1); e = put(e, 8'hff);
                e = mem_disp32(e, 4'd6, r1, req.immediate);
            end
            KIND_POP_M:
            begin
                e = opt_rex_b(e, r1); e = put(e, 8'h8f);
                e = mem_disp32(e, 4'd0, r1, req.immediate);
            end
            KIND_CMP_RR:
            begin
                e = put(e, rexw(r2, r1)); e = put(e, 8'h39); e = put(e, modrm(2'd3, r2, r1));
            end
            KIND_CMP_RI:
            begin
                if (r1 == 4'd0)
                begin
                    // Short accumulator form.
                    e = put(e, 8'h48); e = put(e, 8'h3d);
                end
                else
                begin
                    e = put(e, rexw(4'd0, r1)); e = put(e, 8'h81);
                    e = put(e, modrm(2'd3, 4'd7, r1));
                end
                e = put32(e, req.immediate);
            end
            KIND_EXIT:
            begin
                e = put(e, 8'h48); e = put(e, 8'h31); e = put(e, 8'hff);
                e = put(e, 8'h48); e = put(e, 8'hc7); e = put(e, 8'hc0);
                e = put(e, 8'h3c); e = put(e, 8'h00); e = put(e, 8'h00);
                e = put(e, 8'h00); e = put(e, 8'h0f); e = put(e, 8'h05);
            end
            KIND_IN:      begin e = put(e, 8'h6a); e = put(e, 8'h00); end
            KIND_OUT:     begin e = put(e, 8'h48); e = put(e, 8'h89); e = put(e, 8'hf8); end
            KIND_LEA:
            begin
                e = put(e, rexw(r1, r2)); e = put(e, 8'h8d);
                e = mem_disp32(e, r1, r2, req.immediate);
            end
            KIND_RET:     begin e = put(e, 8'hc3); end
            KIND_SETCC:
            begin
                if (r1 >= 4'd4)
                begin
                    e = put(e, {7'b0100000, r1[3]});
                end
                e = put(e, 8'h0f); e = put(e, {4'h9, req.condition[3:0]});
                e = put(e, {5'b11000, r1[2:0]});
            end
            KIND_CALL:    begin e = put(e, 8'he8); e = put32(e, rel_near); end
            KIND_JMP:
            begin
                if (req.condition[4])
                begin
                    e = put(e, 8'he9); e = put32(e, rel_near);
                end
                else
                begin
                    e = put(e, 8'h0f); e = put(e, {4'h8, req.condition[3:0]});
                    e = put32(e, rel_cond);
                end
            end
            KIND_TEST:
            begin
                e = put(e, rexw(r2, r1)); e = put(e, 8'h85); e = put(e, modrm(2'd3, r2, r1));
            end
            KIND_INC:
            begin
                e = put(e, rexw(4'd0, r1)); e = put(e, 8'hff); e = put(e, modrm(2'd3, 4'd0, r1));
            end
            KIND_DEC:
            begin
                e = put(e, rexw(4'd0, r1)); e = put(e, 8'hff); e = put(e, modrm(2'd3, 4'd1, r1));
            end
            KIND_MOV_RR:
            begin
                e = put(e, rexw(r2, r1)); e = put(e, 8'h89); e = put(e, modrm(2'd3, r2, r1));
            end
            KIND_MOV_RM:
            begin
                e = put(e, rexw(r1, r2)); e = put(e, 8'h8b); e = mem_plain(e, r1, r2);
            end
            KIND_MOV_MR:
            begin
                e = put(e, rexw(r2, r1)); e = put(e, 8'h89); e = mem_plain(e, r2, r1);
            end
            KIND_MOV_RMD:
            begin
                e = put(e, rexw(r1, r2)); e = put(e, 8'h8b);
                e = mem_disp32(e, r1, r2, req.immediate);
            end
            KIND_MOV_MDR:
            begin
                e = put(e, rexw(r2, r1)); e = put(e, 8'h89);
                e = mem_disp32(e, r2, r1, req.immediate);
            end
            KIND_MOV_RI:
            begin
                e = put(e, rexw(4'd0, r1)); e = put(e, 8'hc7);
                e = put(e, modrm(2'd3, 4'd0, r1)); e = put32(e, req.immediate);
            end
            KIND_ALU:
            begin
                e = put(e, rexw(r2, r1)); e = put(e, req.alu_opcode);
                e = put(e, modrm(2'd3, r2, r1));
            end
            KIND_IMUL:
            begin
                e = put(e, rexw(r1, r2)); e = put(e, 8'h0f); e = put(e, 8'haf);
                e = put(e, modrm(2'd3, r1, r2));
            end
            KIND_IDIV:
            begin
                e = put(e, rexw(4'd0, r1)); e = put(e, 8'hf7); e = put(e, modrm(2'd3, 4'd7, r1));
            end
            KIND_SHL:
            begin
                e = put(e, rexw(4'd0, r1)); e = put(e, 8'hd3); e = put(e, modrm(2'd3, 4'd4, r1));
            end
            KIND_SHR:
            begin
                e = put(e, rexw(4'd0, r1)); e = put(e, 8'hd3); e = put(e, modrm(2'd3, 4'd5, r1));
            end
            default:      begin e = '0; end
        endcase
        enc = e;
    end

endmodule : xenc_encoder
`default_nettype wire

### sv/xenc_serializer.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// xenc_serializer: byte output buffer
// Holds one encoded instruction and sends it out one byte per transfer,
// marking the final byte.
// ---------------------------------------------------------------------------
module xenc_serializer
    import xenc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       load,
    input  var enc_t        enc,
    output logic            can_load,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tlast
);

    logic                           valid_reg;
    logic [IDX_W-1:0]               idx_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic [MAX_INSN_BYTES-1:0][7:0] bytes_reg;
    logic                           take;

    assign m_tvalid = valid_reg;
    assign m_tdata  = bytes_reg[idx_reg];
    assign m_tlast  = (CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg;
    assign take     = valid_reg && m_tready;
    // A new instruction may enter while the final byte of the current one goes.
    assign can_load = !valid_reg || (take && m_tlast);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= (enc.count != '0);
            idx_reg   <= '0;
        end
        else if (take)
        begin
            if (m_tlast)
            begin
                valid_reg <= 1'b0;
            end
            idx_reg <= IDX_W'(idx_reg + 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bytes_reg <= enc.bytes;
            cnt_reg   <= enc.count;
        end
    end

endmodule : xenc_serializer
`default_nettype wire

### sv/x86_64_instruction_encoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// x86_64_instruction_encoder_unit: x86-64 machine-code emitter
// Encodes one instruction request per input transfer into its byte sequence.
// ---------------------------------------------------------------------------
// Usage notes.
// The slave channel (s_tvalid, s_tready, s_tdata) takes one instruction
// request per transfer. The master channel (m_tvalid, m_tready, m_tdata,
// m_tlast) returns the encoded machine code one byte per transfer, with
// m_tlast set on the final byte of each instruction.
// An accepted request lands in an input register. From there it is encoded
// combinationally against the running byte position and loaded into the
// output buffer, which presents the first byte. An instruction of N bytes
// then occupies the output for N byte transfers; the output byte rate sets
// the throughput.
// The next request is accepted while the current bytes drain, and it moves to
// the output buffer in the same cycle the final byte transfers, so the byte
// stream has no gaps while the receiver keeps m_tready high.
// Unused kinds produce no bytes and leave the byte position unchanged.
// When the receiver stalls, the current byte holds and the input register
// fills, after which s_tready stays low until the stall clears.
// Reset clears the byte position to zero and empties both registers.
// ---------------------------------------------------------------------------
module x86_64_instruction_encoder_unit
    import xenc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // Fields from bit 0: kind[4:0], first_reg[8:5], second_reg[12:9],
    // condition[17:13], immediate[49:18], target_offset[81:50],
    // alu_opcode[89:82], zero padding[95:90].
    input  wire logic [IN_DATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // Fields from bit 0: code_byte[7:0].
    output logic [7:0]                m_tdata,
    output logic                      m_tlast
);

    logic                     in_valid_reg;
    req_t                     req_reg;
    logic [POSITION_BITS-1:0] position_reg;
    enc_t                     enc;
    logic                     can_load;
    logic                     load;

    assign load     = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            position_reg <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (load)
            begin
                in_valid_reg <= 1'b0;
            end
            // The position advances by the length of each instruction as it
            // enters the output buffer.
            if (load)
            begin
                position_reg <= position_reg + POSITION_BITS'(enc.count);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            req_reg <= req_t'(s_tdata[REQ_W-1:0]);
        end
    end

    xenc_encoder u_encoder (
        .req      (req_reg),
        .position (position_reg),
        .enc      (enc)
    );

    xenc_serializer u_serializer (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .enc      (enc),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule : x86_64_instruction_encoder_unit
`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for x86_64_instruction_encoder_unit
// Streams instruction requests into the encoder and compares every emitted
// machine-code byte and its last-byte flag with an in-bench encoder model
// that tracks the running byte position, under random idling on both sides.
// ---------------------------------------------------------------------------
module tb_top
    import xenc_pkg::*;
;

    // Run length bounds. The limit covers the slowest legal run many times
    // over: every request at twelve bytes, every byte behind a receiver
    // stall and every request behind a sender gap.
    localparam int RANDOM_REQUESTS = 420;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 16;
    localparam int HOLD_CYCLES     = 250;
    localparam int HOLD_AFTER      = 150;

    typedef struct {
        logic [7:0] code;
        logic       last;
    } code_byte_t;

    // The scoreboard holds a software view of the encoder. Each accepted
    // request is encoded against the bench copy of the byte position, and
    // the resulting bytes wait in order for the master channel.
    class byte_stream_board;
        code_byte_t                 expected_bytes[$];
        logic [7:0]                 insn[$];
        logic [POSITION_BITS-1:0]   position;
        int                         errors;

        function new();
            position = '0;
            errors   = 0;
        endfunction

        function void emit(logic [7:0] v);
            if (insn.size() < MAX_INSN_BYTES)
                insn.push_back(v);
        endfunction

        function void emit32(logic [31:0] v);
            for (int i = 0; i < 4; i++)
                emit(v[8*i +: 8]);
        endfunction

        function logic [7:0] rex_w(logic [3:0] rg, logic [3:0] rm);
            return {5'b01001, rg[3], 1'b0, rm[3]};
        endfunction

        function logic [7:0] mod_rm(logic [1:0] md, logic [3:0] rg, logic [3:0] rm);
            return {md, rg[2:0], rm[2:0]};
        endfunction

        function void rex_b(logic [3:0] r);
            if (r[3])
                emit(8'h41);
        endfunction

        // [base + disp32]; rsp and r12 as base need a SIB byte.
        function void mem_disp32(logic [3:0] rg, logic [3:0] base, logic [31:0] disp);
            emit(mod_rm(2'd2, rg, base));
            if (base[2:0] == 3'd4)
                emit(8'h24);
            emit32(disp);
        endfunction

        // Plain [base]; rbp and r13 cannot use mod 00, so a zero disp8 is used.
        function void mem_plain(logic [3:0] rg, logic [3:0] base);
            if (base[2:0] == 3'd5)
            begin
                emit(mod_rm(2'd1, rg, base));
                emit(8'h00);
            end
            else
            begin
                emit(mod_rm(2'd0, rg, base));
                if (base[2:0] == 3'd4)
                    emit(8'h24);
            end
        endfunction

        function void encode_request(req_t r);
            logic [7:0] exit_seq [12];
            logic [3:0] a;
            logic [3:0] b;
            logic [4:0] c;
            logic [31:0] imm;
            exit_seq = '{8'h48, 8'h31, 8'hff, 8'h48, 8'hc7, 8'hc0,
                         8'h3c, 8'h00, 8'h00, 8'h00, 8'h0f, 8'h05};
            a   = r.first_reg;
            b   = r.second_reg;
            c   = r.condition;
            imm = r.immediate;
            insn.delete();
            case (r.kind)
                KIND_CQO:
                begin
                    emit(8'h48); emit(8'h99);
                end
                KIND_PUSH_R:
                begin
                    rex_b(a); emit({5'b01010, a[2:0]});
                end
                KIND_POP_R:
                begin
                    rex_b(a); emit({5'b01011, a[2:0]});
                end
                KIND_PUSH_M:
                begin
                    rex_b(a); emit(8'hff); mem_disp32(4'd6, a, imm);
                end
                KIND_POP_M:
                begin
                    rex_b(a); emit(8'h8f); mem_disp32(4'd0, a, imm);
                end
                KIND_CMP_RR:
                begin
                    emit(rex_w(b, a)); emit(8'h39); emit(mod_rm(2'd3, b, a));
                end
                KIND_CMP_RI:
                begin
                    // rax has the short accumulator form.
                    if (a == 4'd0)
                    begin
                        emit(8'h48);
                        emit(8'h3d);
                    end
                    else
                    begin
                        emit(rex_w(4'd0, a));
                        emit(8'h81);
                        emit(mod_rm(2'd3, 4'd7, a));
                    end
                    emit32(imm);
                end
                KIND_EXIT:    for (int i = 0; i < 12; i++) emit(exit_seq[i]);
                KIND_IN:
                begin
                    emit(8'h6a); emit(8'h00);
                end
                KIND_OUT:
                begin
                    emit(8'h48); emit(8'h89); emit(8'hf8);
                end
                KIND_LEA:
                begin
                    emit(rex_w(a, b)); emit(8'h8d); mem_disp32(a, b, imm);
                end
                KIND_RET:     emit(8'hc3);
                KIND_SETCC:
                begin
                    // Byte registers spl and up need a REX prefix.
                    if (a >= 4'd4)
                        emit({7'b0100000, a[3]});
                    emit(8'h0f);
                    emit({4'h9, c[3:0]});
                    emit({5'b11000, a[2:0]});
                end
                KIND_CALL:
                begin
                    emit(8'he8);
                    emit32(r.target_offset - 32'(position + 5));
                end
                KIND_JMP:
                begin
                    if (c[4])
                    begin
                        emit(8'he9);
                        emit32(r.target_offset - 32'(position + 5));
                    end
                    else
                    begin
                        emit(8'h0f);
                        emit({4'h8, c[3:0]});
                        emit32(r.target_offset - 32'(position + 6));
                    end
                end
                KIND_TEST:
                begin
                    emit(rex_w(b, a)); emit(8'h85); emit(mod_rm(2'd3, b, a));
                end
                KIND_INC:
                begin
                    emit(rex_w(4'd0, a)); emit(8'hff); emit(mod_rm(2'd3, 4'd0, a));
                end
                KIND_DEC:
                begin
                    emit(rex_w(4'd0, a)); emit(8'hff); emit(mod_rm(2'd3, 4'd1, a));
                end
                KIND_MOV_RR:
                begin
                    emit(rex_w(b, a)); emit(8'h89); emit(mod_rm(2'd3, b, a));
                end
                KIND_MOV_RM:
                begin
                    emit(rex_w(a, b)); emit(8'h8b); mem_plain(a, b);
                end
                KIND_MOV_MR:
                begin
                    emit(rex_w(b, a)); emit(8'h89); mem_plain(b, a);
                end
                KIND_MOV_RMD:
                begin
                    emit(rex_w(a, b)); emit(8'h8b); mem_disp32(a, b, imm);
                end
                KIND_MOV_MDR:
                begin
                    emit(rex_w(b, a)); emit(8'h89); mem_disp32(b, a, imm);
                end
                KIND_MOV_RI:
                begin
                    emit(rex_w(4'd0, a));
                    emit(8'hc7);
                    emit(mod_rm(2'd3, 4'd0, a));
                    emit32(imm);
                end
                KIND_ALU:
                begin
                    emit(rex_w(b, a)); emit(r.alu_opcode); emit(mod_rm(2'd3, b, a));
                end
                KIND_IMUL:
                begin
                    emit(rex_w(a, b));
                    emit(8'h0f);
                    emit(8'haf);
                    emit(mod_rm(2'd3, a, b));
                end
                KIND_IDIV:
                begin
                    emit(rex_w(4'd0, a)); emit(8'hf7); emit(mod_rm(2'd3, 4'd7, a));
                end
                KIND_SHL:
                begin
                    emit(rex_w(4'd0, a)); emit(8'hd3); emit(mod_rm(2'd3, 4'd4, a));
                end
                KIND_SHR:
                begin
                    emit(rex_w(4'd0, a)); emit(8'hd3); emit(mod_rm(2'd3, 4'd5, a));
                end
                default:      ;
            endcase
        endfunction

        // Called for every request transfer on the slave channel.
        function void accept_request(req_t r);
            encode_request(r);
            foreach (insn[i])
                expected_bytes.push_back('{insn[i], (i == insn.size() - 1)});
            position = position + POSITION_BITS'(insn.size());
        endfunction

        // Called for every byte transfer on the master channel.
        function void check_byte(logic [7:0] code, logic last);
            code_byte_t want;
            if (expected_bytes.size() == 0)
            begin
                $error("code_byte %h arrived with nothing expected", code);
                errors++;
                return;
            end
            want = expected_bytes.pop_front();
            if (code !== want.code)
            begin
                $error("code_byte mismatch: expected %h, actual %h", want.code, code);
                errors++;
            end
            if (last !== want.last)
            begin
                $error("last_byte mismatch: expected %b, actual %b", want.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_DATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [7:0]           m_tdata;
    logic                 m_tlast;

    // While quiet is set, neither side inserts idle cycles.
    logic                 quiet    = 1'b0;

    byte_stream_board     board;

    x86_64_instruction_encoder_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    function automatic req_t make_req(logic [4:0] kind, logic [3:0] r1, logic [3:0] r2,
                                      logic [4:0] cond, logic [31:0] imm,
                                      logic [31:0] tgt, logic [7:0] opc);
        req_t r;
        r.kind          = kind;
        r.first_reg     = r1;
        r.second_reg    = r2;
        r.condition     = cond;
        r.immediate     = imm;
        r.target_offset = tgt;
        r.alu_opcode    = opc;
        return r;
    endfunction

    // Register numbers that hit the SIB, disp8 and REX corner cases are
    // favored over a flat spread.
    function automatic logic [3:0] pick_reg();
        logic [3:0] corner [6];
        corner = '{4'd0, 4'd4, 4'd5, 4'd12, 4'd13, 4'd15};
        if ($urandom_range(0, 1) == 0)
            return corner[$urandom_range(0, 5)];
        return 4'($urandom);
    endfunction

    function automatic req_t random_request();
        req_t r;
        // Kinds past the last form are rare noise that produces no bytes.
        if ($urandom_range(0, 99) < 3)
            r.kind = 5'($urandom_range(29, 31));
        else
            r.kind = 5'($urandom_range(0, 28));
        r.first_reg  = pick_reg();
        r.second_reg = pick_reg();
        r.condition  = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(0, 16))
                                                   : 5'($urandom_range(0, 31));
        case ($urandom_range(0, 9))
            0:       r.immediate = 32'h8000_0000;
            1:       r.immediate = 32'h7fff_ffff;
            default: r.immediate = $urandom;
        endcase
        r.target_offset = $urandom;
        r.alu_opcode    = 8'($urandom);
        return r;
    endfunction

    // One request transfer on the slave channel, with an occasional idle gap
    // in front of it. The request is noted at the edge that accepts it.
    task automatic send_request(input req_t r);
        if (!quiet && $urandom_range(0, 99) < 9)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W - REQ_W){1'b0}}, r};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.accept_request(r);
    endtask

    // Receiver: checks every byte transfer and decides m_tready for the
    // next cycle. Once, after enough bytes, it holds off for a long stretch
    // so that the input register fills and s_tready drops.
    initial
    begin
        int hold_left;
        int bytes_seen;
        hold_left  = 0;
        bytes_seen = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                board.check_byte(m_tdata, m_tlast);
                bytes_seen++;
                if (bytes_seen == HOLD_AFTER)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 99) < 9)
            begin
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        for (int n = 0; n < CYCLE_LIMIT; n++)
            @(posedge clk);
        $display("x86_64_instruction_encoder_unit regression: fail");
        $finish;
    end

    // Stimulus: a directed sweep, then random requests, then a drain.
    initial
    begin
        int counted;
        req_t r;
        board = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sweep every form once. Odd kinds put r12 in the first slot and r13
        // in the second, even kinds put r13 first and rsp second, so the
        // memory forms meet both SIB and disp8 cases. Fields sit at their
        // extremes and the condition follows the kind, above 16 included.
        for (int k = 0; k <= 29; k++)
        begin
            send_request(make_req(5'(k),
                                  (k % 2) ? 4'd12 : 4'd13,
                                  (k % 2) ? 4'd13 : 4'd4,
                                  5'(k),
                                  (k % 2) ? 32'h7fff_ffff : 32'h8000_0000,
                                  (k % 2) ? 32'hffff_ffff : 32'h0000_0000,
                                  (k % 2) ? 8'hff : 8'h00));
        end
        // Short accumulator form of cmp with an immediate.
        send_request(make_req(KIND_CMP_RI, 4'd0, 4'd15, 5'd0, 32'h1234_5678, 32'd0, 8'd0));
        // setcc on a low byte register needs no REX; conditions above 15 wrap.
        send_request(make_req(KIND_SETCC, 4'd3, 4'd0, 5'd31, 32'd0, 32'd0, 8'd0));
        // Unconditional jumps by the explicit code and by any bit-4 value.
        send_request(make_req(KIND_JMP, 4'd0, 4'd0, 5'd16, 32'd0, 32'd0, 8'd0));
        send_request(make_req(KIND_JMP, 4'd0, 4'd0, 5'd31, 32'd0, 32'h8000_0000, 8'd0));
        // Plain loads and stores through rbp-like and rsp-like bases.
        send_request(make_req(KIND_MOV_RM, 4'd1, 4'd5, 5'd0, 32'd0, 32'd0, 8'd0));
        send_request(make_req(KIND_MOV_MR, 4'd12, 4'd9, 5'd0, 32'd0, 32'd0, 8'd0));

        // Random requests. Kinds that encode nothing do not count.
        counted = 0;
        while (counted < RANDOM_REQUESTS)
        begin
            quiet = (counted >= 200 && counted < 320);
            r = random_request();
            send_request(r);
            if (r.kind <= KIND_SHR)
                counted++;
        end
        quiet = 1'b0;
        s_tvalid <= 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.errors == 0)
            $display("x86_64_instruction_encoder_unit regression: pass");
        else
            $display("x86_64_instruction_encoder_unit regression: fail");
        $finish;
    end

endmodule

### sim.f
sv/xenc_pkg.sv
sv/xenc_encoder.sv
sv/xenc_serializer.sv
sv/x86_64_instruction_encoder_unit.sv
test/tb_top.sv
